// ===== design/oat_pkg.sv =====
// Shared constants for the oriented box versus aligned box overlap unit.
`timescale 1ns / 1ps
package oat_pkg;

    localparam int COORD_W        = 24;
    localparam int CFG_IDX_W      = 3;
    localparam int ANGLE_BITS_DEF = 12;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_SIZE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_SIZE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_SIZE_Z = 3'd5;

    // length of the valid pipeline from an accepted word to its result strobe
    localparam int PIPE_LAT = 6;

    localparam int              TRIG_W      = 15;
    localparam logic [63:0]     TRIG_ONE    = 64'd16384;
    localparam logic [63:0]     Q30_ONE     = 64'd1073741824;
    localparam logic [63:0]     HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0]     TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72,
                                                   64'd42, 64'd20, 64'd6};

endpackage

// ===== design/obb_aabb_overlap_test_unit.sv =====
// Oriented box (yaw only) versus axis-aligned box overlap test, six-stage pipeline.
// Throughput: one word per cycle while o_busy is low; the sine/cosine ROM read
// and the two multiplier stages are each one register stage, so nothing iterates.
// The receiver cannot stall; each result is shown for one cycle only.
// Synchronous active-low reset clears the valid pipeline and the configuration
// registers to zero; o_busy is high during reset and for the first cycle after it.
`timescale 1ns / 1ps
module obb_aabb_overlap_test_unit
    import oat_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic signed [COORD_W-1:0]   i_owner_x,
    input  logic signed [COORD_W-1:0]   i_owner_y,
    input  logic signed [COORD_W-1:0]   i_owner_z,
    input  logic [ANGLE_BITS-1:0]       i_yaw_angle,
    input  logic signed [COORD_W-1:0]   i_aligned_center_x,
    input  logic signed [COORD_W-1:0]   i_aligned_center_y,
    input  logic signed [COORD_W-1:0]   i_aligned_center_z,
    input  logic [COORD_W-1:0]          i_aligned_size_x,
    input  logic [COORD_W-1:0]          i_aligned_size_y,
    input  logic [COORD_W-1:0]          i_aligned_size_z,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [COORD_W-1:0]          i_cfg_data,
    output logic                        o_valid,
    output logic                        o_overlap
);

    localparam int QB  = ANGLE_BITS - 2;
    localparam int QN  = 1 << QB;
    localparam int IW  = ANGLE_BITS - 1;
    localparam int DW  = COORD_W + 2;
    localparam int SW  = TRIG_W + 1;
    localparam int PW  = DW + SW;
    localparam int MW  = COORD_W + TRIG_W;
    localparam int N2W = 2 * TRIG_W;
    localparam int BNW = COORD_W + N2W;
    localparam int CW  = PW + 1 + 15;

    typedef logic [TRIG_W-1:0] t_rom [0:QN];

    function automatic logic [TRIG_W-1:0] quarter_sin(input logic [63:0] k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] e;
        x  = (k * HALF_PI_Q30 + 64'(QN / 2)) >> QB;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int i = 0; i < 6; i++) begin
            t = Q30_ONE - (((x2 * t) >> 30) / TAYLOR_DIV[i]);
        end
        s = (x * t) >> 30;
        e = (s + 64'd32768) >> 16;
        if (e > TRIG_ONE) begin
            e = TRIG_ONE;
        end
        return e[TRIG_W-1:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom rom;
        for (int k = 0; k <= QN; k++) begin
            rom[k] = quarter_sin(64'(k));
        end
        return rom;
    endfunction

    localparam t_rom SIN_ROM = build_rom();

    // configuration
    logic signed [COORD_W-1:0] r_offset_x, r_offset_y, r_offset_z;
    logic [COORD_W-1:0]        r_box_size_x, r_box_size_y, r_box_size_z;
    logic                      r_busy;
    logic [PIPE_LAT-1:0]       r_vld;
    logic                      accept;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = r_busy;
    assign accept      = i_start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_x   <= '0;
            r_offset_y   <= '0;
            r_offset_z   <= '0;
            r_box_size_x <= '0;
            r_box_size_y <= '0;
            r_box_size_z <= '0;
            r_busy       <= 1'b1;
            r_vld        <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[PIPE_LAT-2:0], accept};
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_OFFSET_X:   r_offset_x   <= i_cfg_data;
                    REG_OFFSET_Y:   r_offset_y   <= i_cfg_data;
                    REG_OFFSET_Z:   r_offset_z   <= i_cfg_data;
                    REG_BOX_SIZE_X: r_box_size_x <= i_cfg_data;
                    REG_BOX_SIZE_Y: r_box_size_y <= i_cfg_data;
                    REG_BOX_SIZE_Z: r_box_size_z <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // stage 1: centre difference, ROM addresses
    logic signed [DW-1:0] r1_dx, r1_dy, r1_dz;
    logic [COORD_W-1:0]   r1_asx, r1_asy, r1_asz;
    logic [IW-1:0]        r1_sidx, r1_cidx;
    logic                 r1_sneg, r1_cneg;
    logic [ANGLE_BITS-1:0] cos_ang;
    logic [IW-1:0]        n_sidx, n_cidx;

    assign cos_ang = i_yaw_angle + ANGLE_BITS'(QN);
    assign n_sidx  = i_yaw_angle[QB] ? (IW'(QN) - IW'(i_yaw_angle[QB-1:0]))
                                     : IW'(i_yaw_angle[QB-1:0]);
    assign n_cidx  = cos_ang[QB] ? (IW'(QN) - IW'(cos_ang[QB-1:0]))
                                 : IW'(cos_ang[QB-1:0]);

    always_ff @(posedge i_clk) begin
        r1_dx   <= DW'(i_aligned_center_x) - DW'(i_owner_x) - DW'(r_offset_x);
        r1_dy   <= DW'(i_aligned_center_y) - DW'(i_owner_y) - DW'(r_offset_y);
        r1_dz   <= DW'(i_aligned_center_z) - DW'(i_owner_z) - DW'(r_offset_z);
        r1_asx  <= i_aligned_size_x;
        r1_asy  <= i_aligned_size_y;
        r1_asz  <= i_aligned_size_z;
        r1_sidx <= n_sidx;
        r1_cidx <= n_cidx;
        r1_sneg <= i_yaw_angle[ANGLE_BITS-1];
        r1_cneg <= cos_ang[ANGLE_BITS-1];
    end

    // stage 2: ROM read
    logic signed [SW-1:0] r2_c, r2_s;
    logic [TRIG_W-1:0]    r2_cm, r2_sm;
    logic signed [DW-1:0] r2_dx, r2_dy, r2_dz;
    logic [COORD_W-1:0]   r2_asx, r2_asy, r2_asz;
    logic [TRIG_W-1:0]    n_sm, n_cm;

    assign n_sm = SIN_ROM[r1_sidx];
    assign n_cm = SIN_ROM[r1_cidx];

    always_ff @(posedge i_clk) begin
        r2_sm  <= n_sm;
        r2_cm  <= n_cm;
        r2_s   <= r1_sneg ? -$signed({1'b0, n_sm}) : $signed({1'b0, n_sm});
        r2_c   <= r1_cneg ? -$signed({1'b0, n_cm}) : $signed({1'b0, n_cm});
        r2_dx  <= r1_dx;
        r2_dy  <= r1_dy;
        r2_dz  <= r1_dz;
        r2_asx <= r1_asx;
        r2_asy <= r1_asy;
        r2_asz <= r1_asz;
    end

    // stage 3: products; the y axis test settles here
    logic signed [PW-1:0] r3_dxc, r3_dzs, r3_dxs, r3_dzc;
    logic [N2W-1:0]       r3_cc, r3_ss;
    logic [MW-1:0]        r3_axc, r3_azs, r3_axs, r3_azc;
    logic [MW-1:0]        r3_bxc, r3_bzs, r3_bxs, r3_bzc;
    logic [DW-1:0]        r3_dxa, r3_dza;
    logic [COORD_W-1:0]   r3_asx, r3_asz;
    logic                 r3_sep;
    logic [DW-1:0]        dya;

    assign dya = r2_dy[DW-1] ? DW'(-r2_dy) : DW'(r2_dy);

    always_ff @(posedge i_clk) begin
        r3_dxc <= r2_dx * r2_c;
        r3_dzs <= r2_dz * r2_s;
        r3_dxs <= r2_dx * r2_s;
        r3_dzc <= r2_dz * r2_c;
        r3_cc  <= r2_cm * r2_cm;
        r3_ss  <= r2_sm * r2_sm;
        r3_axc <= r2_asx * r2_cm;
        r3_azs <= r2_asz * r2_sm;
        r3_axs <= r2_asx * r2_sm;
        r3_azc <= r2_asz * r2_cm;
        r3_bxc <= r_box_size_x * r2_cm;
        r3_bzs <= r_box_size_z * r2_sm;
        r3_bxs <= r_box_size_x * r2_sm;
        r3_bzc <= r_box_size_z * r2_cm;
        r3_dxa <= r2_dx[DW-1] ? DW'(-r2_dx) : DW'(r2_dx);
        r3_dza <= r2_dz[DW-1] ? DW'(-r2_dz) : DW'(r2_dz);
        r3_asx <= r2_asx;
        r3_asz <= r2_asz;
        r3_sep <= {1'b0, dya, 1'b0} > ((DW + 2)'(r_box_size_y) + (DW + 2)'(r2_asy));
    end

    // stage 4: world x and z axis tests, projections on the box x and z axes
    logic [PW:0]      r4_px, r4_pz;
    logic [N2W:0]     r4_n2;
    logic [MW:0]      r4_rax, r4_raz;
    logic             r4_sep;
    logic signed [PW:0] px, pz;
    logic [CW-1:0]    lhs_ex, rhs_ex, lhs_ez, rhs_ez;

    assign px     = (PW + 1)'(r3_dxc) - (PW + 1)'(r3_dzs);
    assign pz     = (PW + 1)'(r3_dxs) + (PW + 1)'(r3_dzc);
    assign lhs_ex = CW'({r3_dxa, 15'd0});
    assign lhs_ez = CW'({r3_dza, 15'd0});
    assign rhs_ex = CW'(r3_bxc) + CW'(r3_bzs) + CW'({r3_asx, 14'd0});
    assign rhs_ez = CW'(r3_bxs) + CW'(r3_bzc) + CW'({r3_asz, 14'd0});

    always_ff @(posedge i_clk) begin
        r4_px  <= px[PW] ? (PW + 1)'(-px) : (PW + 1)'(px);
        r4_pz  <= pz[PW] ? (PW + 1)'(-pz) : (PW + 1)'(pz);
        r4_n2  <= (N2W + 1)'(r3_cc) + (N2W + 1)'(r3_ss);
        r4_rax <= (MW + 1)'(r3_axc) + (MW + 1)'(r3_azs);
        r4_raz <= (MW + 1)'(r3_axs) + (MW + 1)'(r3_azc);
        r4_sep <= r3_sep || (lhs_ex > rhs_ex) || (lhs_ez > rhs_ez);
    end

    // stage 5: box extent times squared axis length
    logic [BNW:0]  r5_bxn, r5_bzn;
    logic [PW:0]   r5_px, r5_pz;
    logic [MW:0]   r5_rax, r5_raz;
    logic          r5_sep;

    always_ff @(posedge i_clk) begin
        r5_bxn <= r_box_size_x * r4_n2;
        r5_bzn <= r_box_size_z * r4_n2;
        r5_px  <= r4_px;
        r5_pz  <= r4_pz;
        r5_rax <= r4_rax;
        r5_raz <= r4_raz;
        r5_sep <= r4_sep;
    end

    // stage 6: box x and z axis tests, result word
    logic [CW-1:0] lhs_x, rhs_x, lhs_z, rhs_z;
    logic          r_overlap;

    assign lhs_x = CW'({r5_px, 15'd0});
    assign lhs_z = CW'({r5_pz, 15'd0});
    assign rhs_x = CW'(r5_bxn) + CW'({r5_rax, 14'd0});
    assign rhs_z = CW'(r5_bzn) + CW'({r5_raz, 14'd0});

    always_ff @(posedge i_clk) begin
        r_overlap <= !(r5_sep || (lhs_x > rhs_x) || (lhs_z > rhs_z));
    end

    assign o_valid   = r_vld[PIPE_LAT-1];
    assign o_overlap = r_overlap;

endmodule

// ===== design/oat_checker.sv =====
// Port-level checks for the overlap unit, bound to the top level.
`timescale 1ns / 1ps
module oat_checker
    import oat_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid
);

    // every accepted word yields its result strobe once it has passed through the valid pipeline
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##PIPE_LAT o_valid)
        else $error("accepted word gave no result strobe");

    // no strobe without an accepted word behind it in the valid pipeline
    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, PIPE_LAT))
        else $error("result strobe without an accepted word");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_busy && !o_valid))
        else $error("reset did not flush the pipeline");

endmodule

bind obb_aabb_overlap_test_unit oat_checker u_oat_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid)
);
